FILE: src/icf_pkg.sv
// Shared types, constants and the arctangent table for the IMU attitude fusion block.
// Used by every module under src; depends on nothing.
package icf_pkg;

  localparam int CordicItersDef = 16;
  localparam int XW = 28;   // CORDIC vector component width
  localparam int ZW = 26;   // CORDIC angle width, 1/65536 degree
  localparam int InW = 152;
  localparam int OutW = 96;

  localparam logic [14:0] TurnOut = 15'd23040;
  localparam logic signed [14:0] HalfOut = 15'sd11520;
  localparam logic [16:0] GainInv = 17'd39797;
  localparam logic [16:0] AlphaOne = 17'd65536;

  localparam logic [1:0] CfgAlpha = 2'd0;
  localparam logic [1:0] CfgStep  = 2'd1;
  localparam logic [1:0] CfgGain  = 2'd2;
  localparam logic [1:0] CfgMag   = 2'd3;

  typedef struct packed {
    logic signed [15:0] field_z;
    logic signed [15:0] field_y;
    logic signed [15:0] field_x;
    logic signed [17:0] rate_z;
    logic signed [17:0] rate_y;
    logic signed [17:0] rate_x;
    logic signed [15:0] acc_z;
    logic signed [15:0] acc_y;
    logic signed [15:0] acc_x;
  } icf_item_t;

  typedef struct packed {
    logic                 start;
    logic                 rotate;
    logic signed [XW-1:0] x0;
    logic signed [XW-1:0] y0;
    logic signed [ZW-1:0] z0;
  } cord_cmd_t;

  typedef struct packed {
    logic                 done;
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } cord_rsp_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_SQ_A, ST_SQ_B, ST_SQRT, ST_AT_P, ST_AT_R, ST_AT_M, ST_INIT,
    ST_BL_RATE, ST_BL_LAST, ST_BL_ALPHA, ST_BL_ACC, ST_BL_ROUND,
    ST_HD_RATE, ST_HD_SUM, ST_HD_GAIN, ST_HD_ROUND, ST_WRAP,
    ST_ROT, ST_SCALE_A, ST_SCALE_B, ST_EMIT
  } icf_state_t;

  // atan(2^-i) in 1/65536 degree
  function automatic logic signed [ZW-1:0] atan_entry(input logic [4:0] i);
    logic signed [ZW-1:0] v;
    case (i)
      5'd0:  v = 26'sd2949120;
      5'd1:  v = 26'sd1740967;
      5'd2:  v = 26'sd919879;
      5'd3:  v = 26'sd466945;
      5'd4:  v = 26'sd234379;
      5'd5:  v = 26'sd117304;
      5'd6:  v = 26'sd58666;
      5'd7:  v = 26'sd29335;
      5'd8:  v = 26'sd14668;
      5'd9:  v = 26'sd7334;
      5'd10: v = 26'sd3667;
      5'd11: v = 26'sd1833;
      5'd12: v = 26'sd917;
      5'd13: v = 26'sd458;
      5'd14: v = 26'sd229;
      5'd15: v = 26'sd115;
      5'd16: v = 26'sd57;
      5'd17: v = 26'sd29;
      5'd18: v = 26'sd14;
      5'd19: v = 26'sd7;
      5'd20: v = 26'sd4;
      5'd21: v = 26'sd2;
      5'd22: v = 26'sd1;
      default: v = 26'sd0;
    endcase
    return v;
  endfunction

endpackage

FILE: src/icf_front.sv
// Input side: takes sensor samples off the stream and holds them in a two-entry queue.
// Depends on icf_pkg.
module icf_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // acc_x, acc_y, acc_z, rate_x, rate_y, rate_z, field_x, field_y, field_z
  input  logic [icf_pkg::InW-1:0] s_tdata,
  output logic                  q_valid,
  output icf_pkg::icf_item_t    q_item,
  input  logic                  q_pop
);
  import icf_pkg::*;

  icf_item_t  slots [2];
  icf_item_t  in_item;
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;

  always_comb begin
    in_item.acc_x   = s_tdata[15:0];
    in_item.acc_y   = s_tdata[31:16];
    in_item.acc_z   = s_tdata[47:32];
    in_item.rate_x  = s_tdata[65:48];
    in_item.rate_y  = s_tdata[83:66];
    in_item.rate_z  = s_tdata[101:84];
    in_item.field_x = s_tdata[117:102];
    in_item.field_y = s_tdata[133:118];
    in_item.field_z = s_tdata[149:134];
  end

  assign s_tready = (count != 2'd2);
  assign q_valid  = (count != 2'd0);
  assign q_item   = slots[rd_ptr];
  assign push     = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_pop) rd_ptr <= ~rd_ptr;
      case ({push, q_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= in_item;
  end

endmodule

FILE: src/icf_cordic.sv
// Shared shift-add CORDIC: vectoring (atan2) and rotation, one iteration per cycle.
// Depends on icf_pkg for the command/response types and the arctangent table.
module icf_cordic #(
  parameter int CORDIC_ITERS = icf_pkg::CordicItersDef
) (
  input  logic               clk,
  input  logic               rst,
  input  icf_pkg::cord_cmd_t cmd,
  output icf_pkg::cord_rsp_t rsp
);
  import icf_pkg::*;

  localparam int IterW = (CORDIC_ITERS > 1) ? $clog2(CORDIC_ITERS) : 1;
  localparam logic [IterW-1:0] IterLast = IterW'(CORDIC_ITERS - 1);
  localparam logic signed [ZW-1:0] Deg90  = ZW'(90 * 65536);
  localparam logic signed [ZW-1:0] Deg180 = ZW'(180 * 65536);

  logic                 busy;
  logic                 done;
  logic                 rot_mode;
  logic                 zero;
  logic [IterW-1:0]     iter;
  logic signed [XW-1:0] x, y, tx, ty, px, py;
  logic signed [ZW-1:0] z, at, pz;
  logic                 ccw;

  assign tx  = x >>> iter;
  assign ty  = y >>> iter;
  assign at  = atan_entry(5'(iter));
  assign ccw = rot_mode ? (z >= 0) : !(y > 0);

  // quadrant pre-rotation so the iterations converge
  always_comb begin
    px = cmd.x0;
    py = cmd.y0;
    pz = cmd.rotate ? cmd.z0 : '0;
    if (cmd.rotate) begin
      if (cmd.z0 > Deg90) begin
        px = -cmd.x0;
        py = -cmd.y0;
        pz = cmd.z0 - Deg180;
      end else if (cmd.z0 < -Deg90) begin
        px = -cmd.x0;
        py = -cmd.y0;
        pz = cmd.z0 + Deg180;
      end
    end else if (cmd.x0 < 0) begin
      if (cmd.y0 >= 0) begin
        px = cmd.y0;
        py = -cmd.x0;
        pz = Deg90;
      end else begin
        px = -cmd.y0;
        py = cmd.x0;
        pz = -Deg90;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (iter == IterLast);
      if (cmd.start) busy <= 1'b1;
      else if (busy && (iter == IterLast)) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      x        <= px;
      y        <= py;
      z        <= pz;
      iter     <= '0;
      rot_mode <= cmd.rotate;
      zero     <= !cmd.rotate && (cmd.x0 == 0) && (cmd.y0 == 0);
    end else if (busy) begin
      iter <= iter + 1'b1;
      if (ccw) begin
        x <= x - ty;
        y <= y + tx;
        z <= z - at;
      end else begin
        x <= x + ty;
        y <= y - tx;
        z <= z + at;
      end
    end
  end

  assign rsp.done = done;
  assign rsp.x    = x;
  assign rsp.y    = y;
  assign rsp.z    = zero ? '0 : z;

endmodule

FILE: src/icf_back.sv
// Execution side: sqrt, two or three atan2 passes, blend, heading and tilt compensation,
// sequenced over one shared multiplier and the shared CORDIC. Depends on icf_pkg, icf_cordic.
module icf_back #(
  parameter int CORDIC_ITERS = icf_pkg::CordicItersDef
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [16:0]              blend_alpha,
  input  logic [15:0]              step_time,
  input  logic [15:0]              mag_gain,
  input  logic                     mag_enable,
  input  logic                     q_valid,
  input  icf_pkg::icf_item_t       q_item,
  output logic                     q_pop,
  output logic                     m_tvalid,
  input  logic                     m_tready,
  output logic [icf_pkg::OutW-1:0] m_tdata
);
  import icf_pkg::*;

  localparam logic signed [26:0] Deg180 = 27'(180 * 65536);
  localparam logic signed [26:0] Deg360 = 27'(360 * 65536);

  icf_state_t state, state_next;
  cord_cmd_t  ccmd;
  cord_rsp_t  crsp;

  logic                 wait_c;
  logic                 first;
  logic                 axis;
  logic                 rot_pass;
  logic signed [55:0]   acc;
  logic [47:0]          sq_n;
  logic [48:0]          sq_res;
  logic [4:0]           sq_k;
  logic [48:0]          sq_bit;
  logic [48:0]          sq_trial;
  logic signed [25:0]   acc_p, acc_r, mag_h;
  logic signed [14:0]   last_pitch, last_roll;
  logic [14:0]          last_heading;
  logic signed [19:0]   hraw;
  logic signed [26:0]   err;
  logic signed [26:0]   err_next;
  logic signed [XW-1:0] fa, fb, fc;
  logic signed [36:0]   mul_a;
  logic signed [17:0]   mul_b;
  logic signed [54:0]   prod;
  logic signed [55:0]   scaled;
  logic signed [55:0]   blend_rnd;
  logic signed [26:0]   init_p, init_r, init_h;
  logic [16:0]          alpha_c;
  logic [16:0]          alpha_inv;
  logic [31:0]          sumsq;
  logic                 out_free;
  logic                 wrap_neg, wrap_over;

  function automatic logic signed [14:0] sat_angle(input logic signed [23:0] v);
    logic signed [14:0] r;
    if (v > 24'(HalfOut)) r = HalfOut;
    else if (v < -24'(HalfOut)) r = -HalfOut;
    else r = v[14:0];
    return r;
  endfunction

  function automatic logic [16:0] sat_field(input logic signed [XW-1:0] v);
    logic signed [28:0] s;
    logic signed [20:0] t;
    logic [16:0]        r;
    s = 29'(v) + 29'sd128;
    t = s[28:8];
    if (t > 21'sd65535) r = 17'h0FFFF;
    else if (t < -21'sd65536) r = 17'h10000;
    else r = t[16:0];
    return r;
  endfunction

  icf_cordic #(.CORDIC_ITERS(CORDIC_ITERS)) u_cordic (
    .clk (clk),
    .rst (rst),
    .cmd (ccmd),
    .rsp (crsp)
  );

  assign alpha_c   = (blend_alpha > AlphaOne) ? AlphaOne : blend_alpha;
  assign alpha_inv = AlphaOne - alpha_c;
  assign prod      = mul_a * mul_b;
  assign scaled    = 56'(prod) + 56'sd32768;
  assign blend_rnd = acc + (56'sd1 <<< 31);
  assign init_p    = 27'(acc_p) + 27'sd512;
  assign init_r    = 27'(acc_r) + 27'sd512;
  assign init_h    = 27'(mag_h) + 27'sd512;
  assign sumsq     = acc[31:0] + prod[31:0];
  assign sq_bit    = 49'(1) << {sq_k, 1'b0};
  assign sq_trial  = sq_res + sq_bit;
  assign out_free  = !m_tvalid || m_tready;
  assign wrap_neg  = hraw < 0;
  assign wrap_over = hraw > $signed({5'b0, TurnOut});
  assign q_pop     = (state == ST_EMIT) && out_free;

  // heading error, wrapped once each way
  always_comb begin
    err_next = 27'(mag_h) - $signed({2'b00, last_heading, 10'b0});
    if (err_next > Deg180) err_next = err_next - Deg360;
    if (err_next < -Deg180) err_next = err_next + Deg360;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:     if (q_valid) state_next = ST_SQ_A;
      ST_SQ_A:     state_next = ST_SQ_B;
      ST_SQ_B:     state_next = ST_SQRT;
      ST_SQRT:     if (sq_k == 5'd0) state_next = ST_AT_P;
      ST_AT_P:     if (crsp.done) state_next = ST_AT_R;
      ST_AT_R: begin
        if (crsp.done) begin
          if (mag_enable) state_next = ST_AT_M;
          else state_next = first ? ST_INIT : ST_BL_RATE;
        end
      end
      ST_AT_M:     if (crsp.done) state_next = first ? ST_INIT : ST_BL_RATE;
      ST_INIT:     state_next = ST_WRAP;
      ST_BL_RATE:  state_next = ST_BL_LAST;
      ST_BL_LAST:  state_next = ST_BL_ALPHA;
      ST_BL_ALPHA: state_next = ST_BL_ACC;
      ST_BL_ACC:   state_next = ST_BL_ROUND;
      ST_BL_ROUND: state_next = axis ? ST_HD_RATE : ST_BL_RATE;
      ST_HD_RATE:  state_next = ST_HD_SUM;
      ST_HD_SUM:   state_next = mag_enable ? ST_HD_GAIN : ST_WRAP;
      ST_HD_GAIN:  state_next = ST_HD_ROUND;
      ST_HD_ROUND: state_next = ST_WRAP;
      ST_WRAP: begin
        if (!wrap_neg && !wrap_over) state_next = mag_enable ? ST_ROT : ST_EMIT;
      end
      ST_ROT:      if (crsp.done) state_next = ST_SCALE_A;
      ST_SCALE_A:  state_next = ST_SCALE_B;
      ST_SCALE_B:  state_next = rot_pass ? ST_EMIT : ST_ROT;
      ST_EMIT:     if (out_free) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // multiplier operands and CORDIC commands
  always_comb begin
    mul_a       = '0;
    mul_b       = '0;
    ccmd        = '0;
    ccmd.start  = 1'b0;
    case (state)
      ST_SQ_A: begin
        mul_a = 37'(q_item.acc_y);
        mul_b = 18'(q_item.acc_y);
      end
      ST_SQ_B: begin
        mul_a = 37'(q_item.acc_z);
        mul_b = 18'(q_item.acc_z);
      end
      ST_AT_P: begin
        ccmd.start = !wait_c;
        ccmd.x0    = $signed({1'b0, sq_res[26:0]});
        ccmd.y0    = -(28'(q_item.acc_x) <<< 8);
      end
      ST_AT_R: begin
        ccmd.start = !wait_c;
        ccmd.x0    = 28'(q_item.acc_z) <<< 8;
        ccmd.y0    = 28'(q_item.acc_y) <<< 8;
      end
      ST_AT_M: begin
        ccmd.start = !wait_c;
        ccmd.x0    = 28'(q_item.field_x) <<< 8;
        ccmd.y0    = -(28'(q_item.field_y) <<< 8);
      end
      ST_BL_RATE: begin
        mul_a = axis ? -37'(q_item.rate_z) : 37'(q_item.rate_y);
        mul_b = $signed({2'b00, step_time});
      end
      ST_BL_ALPHA: begin
        mul_a = acc[36:0];
        mul_b = $signed({1'b0, alpha_c});
      end
      ST_BL_ACC: begin
        mul_a = axis ? 37'(acc_r) : 37'(acc_p);
        mul_b = $signed({1'b0, alpha_inv});
      end
      ST_HD_RATE: begin
        mul_a = 37'(q_item.rate_x);
        mul_b = $signed({2'b00, step_time});
      end
      ST_HD_GAIN: begin
        mul_a = 37'(err);
        mul_b = $signed({2'b00, mag_gain});
      end
      ST_ROT: begin
        ccmd.start  = !wait_c;
        ccmd.rotate = 1'b1;
        if (rot_pass) begin
          ccmd.x0 = 28'(q_item.field_x) <<< 8;
          ccmd.y0 = fb;
          ccmd.z0 = -(26'(last_pitch) <<< 10);
        end else begin
          ccmd.x0 = 28'(q_item.field_y) <<< 8;
          ccmd.y0 = 28'(q_item.field_z) <<< 8;
          ccmd.z0 = 26'(last_roll) <<< 10;
        end
      end
      ST_SCALE_A: begin
        mul_a = 37'(crsp.x);
        mul_b = $signed({1'b0, GainInv});
      end
      ST_SCALE_B: begin
        mul_a = 37'(crsp.y);
        mul_b = $signed({1'b0, GainInv});
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      wait_c       <= 1'b0;
      first        <= 1'b1;
      last_pitch   <= '0;
      last_roll    <= '0;
      last_heading <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      state <= state_next;
      if (ccmd.start) wait_c <= 1'b1;
      else if (crsp.done) wait_c <= 1'b0;
      if ((state == ST_EMIT) && out_free) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      case (state)
        ST_INIT: begin
          last_pitch <= sat_angle(24'($signed(init_p[26:10])));
          last_roll  <= sat_angle(24'($signed(init_r[26:10])));
          first      <= 1'b0;
        end
        ST_BL_ROUND: begin
          if (axis) last_roll <= sat_angle(blend_rnd[55:32]);
          else last_pitch <= sat_angle(blend_rnd[55:32]);
        end
        ST_WRAP: if (!wrap_neg && !wrap_over) last_heading <= hraw[14:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_SQ_A: begin
        acc      <= 56'(prod);
        axis     <= 1'b0;
        rot_pass <= 1'b0;
      end
      ST_SQ_B: begin
        sq_n   <= {sumsq[31:0], 16'b0};
        sq_res <= '0;
        sq_k   <= 5'd24;
      end
      ST_SQRT: begin
        if ({1'b0, sq_n} >= sq_trial) begin
          sq_n   <= sq_n - sq_trial[47:0];
          sq_res <= (sq_res >> 1) + sq_bit;
        end else begin
          sq_res <= sq_res >> 1;
        end
        sq_k <= sq_k - 5'd1;
      end
      ST_AT_P: if (crsp.done) acc_p <= crsp.z;
      ST_AT_R: if (crsp.done) acc_r <= crsp.z;
      ST_AT_M: if (crsp.done) mag_h <= (crsp.z < 0) ? crsp.z + 26'(Deg360) : crsp.z;
      ST_INIT: hraw <= mag_enable ? 20'($signed(init_h[26:10])) : '0;
      ST_BL_RATE:  acc <= 56'(prod);
      ST_BL_LAST:  acc <= acc + (56'(axis ? last_roll : last_pitch) <<< 16);
      ST_BL_ALPHA: acc <= 56'(prod);
      ST_BL_ACC:   acc <= acc + (56'(prod) <<< 6);
      ST_BL_ROUND: axis <= ~axis;
      ST_HD_RATE:  acc <= 56'(prod);
      ST_HD_SUM: begin
        if (mag_enable) begin
          acc <= (acc <<< 10) + $signed({15'b0, last_heading, 26'b0});
          err <= err_next;
        end else begin
          hraw <= 20'((acc + $signed({25'b0, last_heading, 16'b0}) + 56'sd32768) >>> 16);
        end
      end
      ST_HD_GAIN:  acc <= acc + 56'(prod);
      ST_HD_ROUND: hraw <= 20'((acc + (56'sd1 <<< 25)) >>> 26);
      ST_WRAP: begin
        // step into 0..360 one turn at a time
        if (wrap_neg) hraw <= hraw + $signed({5'b0, TurnOut});
        else if (wrap_over) hraw <= hraw - $signed({5'b0, TurnOut});
      end
      ST_SCALE_A: begin
        if (rot_pass) fc <= scaled[43:16];
        else fa <= scaled[43:16];
      end
      ST_SCALE_B: begin
        fb       <= scaled[43:16];
        rot_pass <= 1'b1;
      end
      ST_EMIT: begin
        if (out_free) begin
          m_tdata[14:0]  <= last_pitch;
          m_tdata[29:15] <= last_roll;
          m_tdata[44:30] <= last_heading;
          m_tdata[61:45] <= mag_enable ? sat_field(fc) : '0;
          m_tdata[78:62] <= mag_enable ? sat_field(fa) : '0;
          m_tdata[95:79] <= mag_enable ? sat_field(fb) : '0;
        end
      end
      default: ;
    endcase
  end

  a_pop_has_item: assert property (@(posedge clk) disable iff (rst) q_pop |-> q_valid)
    else $error("queue popped while empty");
  a_done_expected: assert property (@(posedge clk) disable iff (rst) crsp.done |-> wait_c)
    else $error("cordic finished without an outstanding command");
  a_pitch_range: assert property (@(posedge clk) disable iff (rst)
      (last_pitch <= HalfOut) && (last_pitch >= -HalfOut))
    else $error("stored pitch out of range");
  a_heading_range: assert property (@(posedge clk) disable iff (rst)
      last_heading <= TurnOut)
    else $error("stored heading above one turn");
  a_emit_source: assert property (@(posedge clk) disable iff (rst)
      $rose(m_tvalid) |-> $past(state) == ST_EMIT)
    else $error("result raised outside the emit step");

endmodule

FILE: src/imu_complementary_filter_tilt_comp_unit.sv
// Complementary-filter attitude and heading unit with tilt-compensated magnetometer output.
// Samples with the magnetometer enabled take longer (a third atan2 pass and two rotations),
// and the heading wrap adds one step per turn that the heading lies out of range.
// One sample is worked at a time; the shared CORDIC and the 25-step square root set the pace.
// A two-entry input queue and the output register let both sides stall on their own.
// Reset (synchronous, rst high): registers to defaults, angles to 0, next sample initializes.
module imu_complementary_filter_tilt_comp_unit #(
  parameter int CORDIC_ITERS = icf_pkg::CordicItersDef
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  // acc_x, acc_y, acc_z, rate_x, rate_y, rate_z, field_x, field_y, field_z
  input  logic [icf_pkg::InW-1:0]  s_tdata,
  output logic                     m_tvalid,
  input  logic                     m_tready,
  // pitch_angle, roll_angle, heading_angle, comp_field_x, comp_field_y, comp_field_z
  output logic [icf_pkg::OutW-1:0] m_tdata,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [1:0]               cfg_index,
  input  logic [16:0]              cfg_data
);
  import icf_pkg::*;

  logic [16:0] blend_alpha;
  logic [15:0] step_time;
  logic [15:0] mag_gain;
  logic        mag_enable;
  logic        q_valid;
  logic        q_pop;
  icf_item_t   q_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      blend_alpha <= 17'd64225;
      step_time   <= 16'd1049;
      mag_gain    <= 16'd1311;
      mag_enable  <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CfgAlpha: blend_alpha <= cfg_data;
        CfgStep:  step_time   <= cfg_data[15:0];
        CfgGain:  mag_gain    <= cfg_data[15:0];
        CfgMag:   mag_enable  <= cfg_data[0];
        default:  ;
      endcase
    end
  end

  icf_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  icf_back #(.CORDIC_ITERS(CORDIC_ITERS)) u_back (
    .clk         (clk),
    .rst         (rst),
    .blend_alpha (blend_alpha),
    .step_time   (step_time),
    .mag_gain    (mag_gain),
    .mag_enable  (mag_enable),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_pop       (q_pop),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata)
  );

endmodule

FILE: test/imu_complementary_filter_tilt_comp_unit_tb.sv
// Self-checking testbench for the IMU complementary-filter attitude and heading unit.
// Needs icf_pkg and the unit under src; a scoreboard class predicts every result.
`timescale 1ns / 100ps

module imu_complementary_filter_tilt_comp_unit_tb;
  import icf_pkg::*;

  localparam longint DegQ = 65536;

  logic             clk;
  logic             rst;
  logic             s_tvalid;
  logic             s_tready;
  logic [InW-1:0]   s_tdata;    // acc_x, acc_y, acc_z, rate_x, rate_y, rate_z, field_x..z
  logic             m_tvalid;
  logic             m_tready;
  logic [OutW-1:0]  m_tdata;    // pitch, roll, heading, comp_field_x, comp_field_y, comp_field_z
  logic             cfg_valid;
  logic             cfg_ready;
  logic [1:0]       cfg_index;
  logic [16:0]      cfg_data;

  typedef struct packed {
    logic [16:0] cz;
    logic [16:0] cy;
    logic [16:0] cx;
    logic [14:0] hd;
    logic [14:0] rl;
    logic [14:0] pt;
  } attitude_t;

  class attitude_scoreboard;
    longint    alpha_r, step_r, gain_r, mag_r;
    bit        first;
    longint    pitch_s, roll_s, head_s;
    attitude_t expected_q[$];
    int        errors;
    int        matched;

    function new();
      alpha_r = 64225; step_r = 1049; gain_r = 1311; mag_r = 0;
      first = 1; pitch_s = 0; roll_s = 0; head_s = 0;
      errors = 0; matched = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [16:0] val);
      case (idx)
        CfgAlpha: alpha_r = longint'(val);
        CfgStep:  step_r = longint'(val[15:0]);
        CfgGain:  gain_r = longint'(val[15:0]);
        CfgMag:   mag_r = longint'(val[0]);
        default:  ;
      endcase
    endfunction

    function longint clamp(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function longint int_sqrt(longint n);
      longint res, bit_v;
      res = 0; bit_v = 64'd1 << 48;
      while (bit_v > n) bit_v = bit_v >> 2;
      while (bit_v != 0) begin
        if (n >= res + bit_v) begin
          n = n - (res + bit_v);
          res = (res >> 1) + bit_v;
        end else begin
          res = res >> 1;
        end
        bit_v = bit_v >> 2;
      end
      return res;
    endfunction

    function longint arctan2(longint y, longint x);
      longint z, t, tx, ty;
      z = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
        if (y >= 0) begin
          t = x; x = y; y = -t; z = 90 * DegQ;
        end else begin
          t = x; x = -y; y = t; z = -90 * DegQ;
        end
      end
      for (int i = 0; i < CordicItersDef; i++) begin
        tx = x >>> i; ty = y >>> i;
        if (y > 0) begin
          x += ty; y -= tx; z += longint'(atan_entry(5'(i)));
        end else begin
          x -= ty; y += tx; z -= longint'(atan_entry(5'(i)));
        end
      end
      return z;
    endfunction

    function void spin(inout longint a, inout longint b, input longint th);
      longint x, y, tx, ty;
      x = a; y = b;
      if (th > 90 * DegQ) begin
        x = -x; y = -y; th -= 180 * DegQ;
      end else if (th < -90 * DegQ) begin
        x = -x; y = -y; th += 180 * DegQ;
      end
      for (int i = 0; i < CordicItersDef; i++) begin
        tx = x >>> i; ty = y >>> i;
        if (th >= 0) begin
          x -= ty; y += tx; th -= longint'(atan_entry(5'(i)));
        end else begin
          x += ty; y -= tx; th += longint'(atan_entry(5'(i)));
        end
      end
      a = (x * 39797 + 32768) >>> 16;
      b = (y * 39797 + 32768) >>> 16;
    endfunction

    function longint wrap360(longint h);
      longint r;
      if (h < 0) begin
        r = (-h) % 23040;
        return r != 0 ? 23040 - r : 0;
      end
      if (h > 23040) return (h - 1) % 23040 + 1;
      return h;
    endfunction

    function longint compass(longint mx, longint my);
      longint h;
      h = arctan2(-my * 256, mx * 256);
      if (h < 0) h += 360 * DegQ;
      return h;
    endfunction

    function logic [16:0] field_round(longint v);
      longint s;
      s = clamp((v + 128) >>> 8, -65536, 65535);
      return s[16:0];
    endfunction

    function void note_sample(icf_item_t it);
      longint ax, ay, az, gx, gy, gz, mx, my, mz;
      longint acc_p, acc_r, p, r, h, al, pp, pr, sp, sr, err, s, a, b, c;
      attitude_t e;
      ax = longint'(it.acc_x); ay = longint'(it.acc_y); az = longint'(it.acc_z);
      gx = longint'(it.rate_x); gy = longint'(it.rate_y); gz = longint'(it.rate_z);
      mx = longint'(it.field_x); my = longint'(it.field_y); mz = longint'(it.field_z);
      acc_p = arctan2(-ax * 256, int_sqrt((ay * ay + az * az) << 16));
      acc_r = arctan2(ay * 256, az * 256);
      if (first) begin
        p = clamp((acc_p + 512) >>> 10, -11520, 11520);
        r = clamp((acc_r + 512) >>> 10, -11520, 11520);
        h = mag_r != 0 ? wrap360((compass(mx, my) + 512) >>> 10) : 0;
        first = 0;
      end else begin
        al = alpha_r > 65536 ? 65536 : alpha_r;
        pp = pitch_s * 65536 + gy * step_r;
        pr = roll_s * 65536 - gz * step_r;
        sp = al * pp + (65536 - al) * acc_p * 64;
        sr = al * pr + (65536 - al) * acc_r * 64;
        p = clamp((sp + (64'sd1 << 31)) >>> 32, -11520, 11520);
        r = clamp((sr + (64'sd1 << 31)) >>> 32, -11520, 11520);
        if (mag_r != 0) begin
          err = compass(mx, my) - head_s * 1024;
          if (err > 180 * DegQ) err -= 360 * DegQ;
          if (err < -180 * DegQ) err += 360 * DegQ;
          s = head_s * (64'sd1 << 26) + gx * step_r * 1024 + gain_r * err;
          h = wrap360((s + (64'sd1 << 25)) >>> 26);
        end else begin
          h = wrap360((head_s * 65536 + gx * step_r + 32768) >>> 16);
        end
      end
      pitch_s = p; roll_s = r; head_s = h;
      e.pt = p[14:0]; e.rl = r[14:0]; e.hd = h[14:0];
      if (mag_r != 0) begin
        a = my * 256; b = mz * 256; c = mx * 256;
        spin(a, b, r * 1024);
        spin(c, b, -p * 1024);
        e.cx = field_round(c); e.cy = field_round(a); e.cz = field_round(b);
      end else begin
        e.cx = '0; e.cy = '0; e.cz = '0;
      end
      expected_q.push_back(e);
    endfunction

    task report(string what, logic [16:0] got, logic [16:0] want);
      errors++;
      $display("mismatch %0s: got %0h want %0h (result %0d)", what, got, want, matched);
    endtask

    task check_result(attitude_t got);
      attitude_t w;
      if (expected_q.size() == 0) begin
        report("unexpected result", 17'(got.pt), 17'd0);
        return;
      end
      w = expected_q.pop_front();
      if (got.pt !== w.pt) report("pitch_angle", 17'(got.pt), 17'(w.pt));
      if (got.rl !== w.rl) report("roll_angle", 17'(got.rl), 17'(w.rl));
      if (got.hd !== w.hd) report("heading_angle", 17'(got.hd), 17'(w.hd));
      if (got.cx !== w.cx) report("comp_field_x", got.cx, w.cx);
      if (got.cy !== w.cy) report("comp_field_y", got.cy, w.cy);
      if (got.cz !== w.cz) report("comp_field_z", got.cz, w.cz);
      matched++;
    endtask
  endclass

  attitude_scoreboard sb;
  int  sent;

  imu_complementary_filter_tilt_comp_unit DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // monitors
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (s_tvalid && s_tready) sb.note_sample(icf_item_t'(s_tdata[149:0]));
      if (m_tvalid && m_tready) sb.check_result(attitude_t'(m_tdata));
    end
  end

  // receiver: random runs of ready/stall, plus one long hold-off to back up the input
  initial begin
    int run;
    int cyc;
    bit lvl;
    run = 0; cyc = 0; lvl = 1;
    m_tready = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc >= 4000 && cyc < 6000) begin
        m_tready <= 0;
      end else begin
        if (run == 0) begin
          run = $urandom_range(1, 30);
          lvl = $urandom_range(0, 2) != 0;
        end
        run--;
        m_tready <= lvl;
      end
    end
  end

  // hold valid until accepted; the caller drops valid after the last write
  task write_reg(logic [1:0] idx, logic [16:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
  endtask

  task drain();
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task set_all(logic [16:0] al, logic [15:0] st, logic [15:0] gn, logic mg);
    drain();
    write_reg(CfgAlpha, al);
    write_reg(CfgStep, {1'b0, st});
    write_reg(CfgGain, {1'b0, gn});
    write_reg(CfgMag, {16'd0, mg});
    cfg_valid <= 0;
  endtask

  // offer one sample and hold it until accepted; valid stays high across back-to-back items
  task send_sample(icf_item_t it);
    s_tvalid <= 1;
    s_tdata  <= {2'b00, it};
    do @(posedge clk); while (!(s_tvalid && s_tready));
    sent++;
  endtask

  task pause(int n);
    if (n > 0) begin
      s_tvalid <= 0;
      repeat (n) @(posedge clk);
    end
  endtask

  function automatic icf_item_t rand_sample();
    icf_item_t it;
    logic [149:0] raw;
    if ($urandom_range(0, 3) == 0) begin
      raw = 150'({$urandom, $urandom, $urandom, $urandom, $urandom});
      it = icf_item_t'(raw);
    end else begin
      it.acc_x   = 16'($signed($urandom_range(0, 32000)) - 16000);
      it.acc_y   = 16'($signed($urandom_range(0, 32000)) - 16000);
      it.acc_z   = 16'($signed($urandom_range(0, 32000)) - 16000);
      it.rate_x  = 18'($signed($urandom_range(0, 8000)) - 4000);
      it.rate_y  = 18'($signed($urandom_range(0, 8000)) - 4000);
      it.rate_z  = 18'($signed($urandom_range(0, 8000)) - 4000);
      it.field_x = 16'($signed($urandom_range(0, 20000)) - 10000);
      it.field_y = 16'($signed($urandom_range(0, 20000)) - 10000);
      it.field_z = 16'($signed($urandom_range(0, 20000)) - 10000);
    end
    return it;
  endfunction

  task random_burst(int count);
    int left, burst;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, 8);
      for (int k = 0; k < burst && left > 0; k++) begin
        send_sample(rand_sample());
        left--;
      end
      pause($urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 25));
    end
    s_tvalid <= 0;
  endtask

  task directed();
    icf_item_t it;
    it = '0;
    send_sample(it);                      // zero vectors everywhere
    it.acc_x = 16'sh7FFF; it.acc_y = 16'sh7FFF; it.acc_z = 16'sh7FFF;
    it.rate_x = 18'sh1FFFF; it.rate_y = 18'sh1FFFF; it.rate_z = 18'sh1FFFF;
    it.field_x = 16'sh7FFF; it.field_y = 16'sh7FFF; it.field_z = 16'sh7FFF;
    send_sample(it);
    it.acc_x = 16'sh8000; it.acc_y = 16'sh8000; it.acc_z = 16'sh8000;
    it.rate_x = 18'sh20000; it.rate_y = 18'sh20000; it.rate_z = 18'sh20000;
    it.field_x = 16'sh8000; it.field_y = 16'sh8000; it.field_z = 16'sh8000;
    send_sample(it);
    // pitch near +-90 degrees, roll past 90 degrees, heading wrap either way
    it = '0; it.acc_x = 16'sh8000; it.rate_y = 18'sh1FFFF; it.field_x = -16'sd100;
    send_sample(it);
    it = '0; it.acc_x = 16'sh7FFF; it.rate_y = 18'sh20000; it.field_y = 16'sd5;
    send_sample(it);
    it = '0; it.acc_y = 16'sd1000; it.acc_z = -16'sd16000; it.rate_z = 18'sh20000;
    it.field_x = 16'sd3000; it.field_y = -16'sd20; it.field_z = 16'sd4000;
    send_sample(it);
    it = '0; it.acc_y = -16'sd1000; it.acc_z = -16'sd16000; it.rate_x = 18'sh20000;
    it.field_x = -16'sd3000; it.field_y = 16'sd20; it.field_z = -16'sd4000;
    send_sample(it);
    it = '0; it.acc_z = 16'sd16384; it.rate_x = 18'sh1FFFF; it.field_x = 16'sd1;
    repeat (4) send_sample(it);
    it.rate_x = 18'sh20000; it.field_x = -16'sd1; it.field_y = -16'sd1;
    repeat (4) send_sample(it);
    s_tvalid <= 0;
  endtask

  initial begin
    sb = new();
    sent = 0;
    rst = 1;
    s_tvalid = 0; s_tdata = '0;
    cfg_valid = 0; cfg_index = CfgAlpha; cfg_data = '0;
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // first sample under reset settings, without magnetometer
    directed();
    set_all(17'd64225, 16'd1049, 16'd1311, 1'b1);
    directed();
    random_burst(60);
    set_all(17'd0, 16'd65535, 16'd65535, 1'b1);
    random_burst(55);
    set_all(17'd65536, 16'd0, 16'd0, 1'b1);
    random_burst(55);
    set_all(17'd131071, 16'd300, 16'd40000, 1'b0);
    random_burst(55);
    set_all(17'd32768, 16'd65535, 16'd0, 1'b0);
    random_burst(55);
    set_all(17'd100000, 16'd1049, 16'd65535, 1'b1);
    random_burst(60);
    set_all(17'd64225, 16'd1049, 16'd1311, 1'b1);
    random_burst(60);
    drain();
    repeat (200) @(posedge clk);
    $display("covered %0d samples across eight register settings, %0d results checked",
             sent, sb.matched);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/icf_pkg.sv
src/icf_front.sv
src/icf_cordic.sv
src/icf_back.sv
src/imu_complementary_filter_tilt_comp_unit.sv
test/imu_complementary_filter_tilt_comp_unit_tb.sv
